// File: rtl/core/four_way_lru_tag_cache_defines.svh
// Assertion macros for the four-way LRU tag cache.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FOUR_WAY_LRU_TAG_CACHE_DEFINES_SVH
`define FOUR_WAY_LRU_TAG_CACHE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define FWLRU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FWLRU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fwlru_pkg.sv
// Shared types, constants and helpers for the four-way LRU tag cache.
// No dependencies; imported by fwlru_way_sel, the top level and the testbench.
package fwlru_pkg;

	localparam int NUM_SETS_DEF  = 64;
	localparam int ADDR_BITS_DEF = 32;

	localparam int ADDR_W  = 32;
	localparam int CNT_W   = 32;
	localparam int WAYS    = 4;
	localparam int WAY_W   = 2;
	localparam int RANK_W  = 2;
	localparam int RANKS_W = WAYS * RANK_W;
	localparam int OFF_W   = 3;
	localparam int OUT_W   = 104;

	localparam logic [OFF_W-1:0]   OFF_MIN   = 3'd3;
	localparam logic [OFF_W-1:0]   OFF_RESET = 3'd7;
	localparam logic [RANKS_W-1:0] LRU_RESET = 8'hE4;
	localparam logic [RANK_W-1:0]  RANK_OLD  = 2'd0;
	localparam logic [RANK_W-1:0]  RANK_NEW  = 2'd3;

	typedef enum logic {
		ACT_READ  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_W-1:0]     way;
		logic [RANKS_W-1:0]   ranks;
	} sel_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
		logic [CNT_W-1:0] r;
		r = v;
		if (en && (v != '1)) begin
			r = v + CNT_W'(1);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/fwlru_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module fwlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fwlru_way_sel.sv
// Way selection for one set: tag compare, LRU victim and rank update.
// Depends on fwlru_pkg.
module fwlru_way_sel #(
	parameter int TAG_W = 23
) (
	input  fwlru_pkg::action_t                            action,
	input  logic [TAG_W-1:0]                              tag,
	input  logic [fwlru_pkg::WAYS-1:0][TAG_W-1:0]         tags,
	input  logic [fwlru_pkg::RANKS_W-1:0]                 ranks,
	output fwlru_pkg::sel_t                               sel
);

	import fwlru_pkg::*;

	logic               hit;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   victim;
	logic [WAY_W-1:0]   way;
	logic [RANK_W-1:0]  old_rank;
	logic [RANKS_W-1:0] new_ranks;

	// lowest matching way wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (tags[i] == tag) begin
				hit     = (action == ACT_READ);
				hit_way = WAY_W'(i);
			end
		end
	end

	always_comb begin
		victim = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (ranks[i*RANK_W +: RANK_W] == RANK_OLD) begin
				victim = WAY_W'(i);
			end
		end
	end

	assign way      = hit ? hit_way : victim;
	assign old_rank = ranks[way*RANK_W +: RANK_W];

	always_comb begin
		logic [RANK_W-1:0] k;
		new_ranks = '0;
		for (int i = 0; i < WAYS; i++) begin
			k = ranks[i*RANK_W +: RANK_W];
			if (WAY_W'(i) == way) begin
				k = RANK_NEW;
			end else if (k > old_rank) begin
				k = k - RANK_W'(1);
			end
			new_ranks[i*RANK_W +: RANK_W] = k;
		end
	end

	assign sel.hit   = hit;
	assign sel.way   = way;
	assign sel.ranks = new_ranks;

endmodule

// File: rtl/core/four_way_lru_tag_cache.sv
// Top level of the four-way LRU tag cache: address decode, set RAM, bypass, counters.
// Depends on fwlru_pkg, fwlru_ram, fwlru_way_sel and four_way_lru_tag_cache_defines.svh.
//
// Channel  | Dir | Signals                        | Contents
// s_axis   | in  | tvalid tready tdata[31:0] tuser | tdata: address; tuser: action
// m_axis   | out | tvalid tready tdata[103:0]     | hit, way, hit/miss/fill counts
// cfg      | in  | valid ready data[2:0]          | offset_bits
//
// A result passes through the s1 and s2 registers; one access per cycle sustained while m_axis_tready is high.
// The set row is read from the RAM in the accept cycle and written back when the access leaves s1;
// a back-to-back access to the same set takes the row from a bypass register.
// After reset a clearing pass fills every set; s_axis_tready stays low.
// The input stalls only during the clearing pass or when a result is held by m_axis_tready low.
`include "four_way_lru_tag_cache_defines.svh"

module four_way_lru_tag_cache #(
	parameter int NUM_SETS  = fwlru_pkg::NUM_SETS_DEF,
	parameter int ADDR_BITS = fwlru_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fwlru_pkg::OFF_W-1:0]  cfg_data,       // offset_bits
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [fwlru_pkg::ADDR_W-1:0] s_axis_tdata,   // [31:0] address
	input  logic                         s_axis_tuser,   // [0] action
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [fwlru_pkg::OUT_W-1:0]  m_axis_tdata    // [0] hit, [2:1] way,
	                                                     // [34:3] hit_count,
	                                                     // [66:35] miss_count,
	                                                     // [98:67] fill_count, rest 0
);

	import fwlru_pkg::*;

	localparam int SET_W = $clog2(NUM_SETS);
	localparam int EFF_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_W = EFF_W - 3 - SET_W;
	localparam int TAGS_W = WAYS * TAG_W;
	localparam int ROW_W = TAGS_W + RANKS_W;
	localparam logic [ROW_W-1:0] RESET_ROW = {LRU_RESET, {TAGS_W{1'b0}}};
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

	logic [OFF_W-1:0] off_q;
	logic             clearing_q;
	logic [SET_W-1:0] clr_idx_q;

	logic [OFF_W-1:0] off_eff;
	logic [EFF_W-1:0] block;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;
	logic             s_acc;
	logic             s2_free;
	logic             s1_adv;

	logic             valid_s1;
	action_t          action_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] new_row;
	logic             ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;

	logic             byp_valid_q;
	logic [SET_W-1:0] byp_set_q;
	logic [ROW_W-1:0] byp_row_q;

	logic [WAYS-1:0][TAG_W-1:0] tags_s1;
	logic [WAYS-1:0][TAG_W-1:0] new_tags;
	logic [RANKS_W-1:0]         ranks_s1;
	sel_t                       sel;

	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] fill_cnt_q;
	logic [CNT_W-1:0] hit_cnt_nx;
	logic [CNT_W-1:0] miss_cnt_nx;
	logic [CNT_W-1:0] fill_cnt_nx;

	logic             valid_s2;
	logic             hit_s2;
	logic [WAY_W-1:0] way_s2;
	logic [CNT_W-1:0] hit_cnt_s2;
	logic [CNT_W-1:0] miss_cnt_s2;
	logic [CNT_W-1:0] fill_cnt_s2;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OFF_RESET;
		end else if (cfg_valid) begin
			off_q <= cfg_data;
		end
	end

	// handshake
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign s1_adv        = valid_s1 && s2_free;
	assign s_axis_tready = !clearing_q && (!valid_s1 || s2_free);
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// address decode
	assign off_eff = (off_q < OFF_MIN) ? OFF_MIN : off_q;
	assign block   = s_axis_tdata[EFF_W-1:0] >> off_eff;
	assign set_in  = block[SET_W-1:0];
	assign tag_in  = TAG_W'(block >> SET_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			action_s1 <= action_t'(s_axis_tuser);
			set_s1    <= set_in;
			tag_s1    <= tag_in;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + SET_W'(1);
			if (clr_idx_q == LAST_SET) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clearing_q || s1_adv;
	assign ram_waddr = clearing_q ? clr_idx_q : set_s1;
	assign ram_wdata = clearing_q ? RESET_ROW : new_row;

	fwlru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_set_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (s_acc),
		.raddr (set_in),
		.rdata (ram_rdata)
	);

	// last written row, covers a read that raced its write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			byp_set_q <= set_s1;
			byp_row_q <= new_row;
		end
	end

	assign row_s1   = (byp_valid_q && byp_set_q == set_s1) ? byp_row_q : ram_rdata;
	assign tags_s1  = row_s1[TAGS_W-1:0];
	assign ranks_s1 = row_s1[ROW_W-1:TAGS_W];

	fwlru_way_sel #(
		.TAG_W (TAG_W)
	) u_way_sel (
		.action (action_s1),
		.tag    (tag_s1),
		.tags   (tags_s1),
		.ranks  (ranks_s1),
		.sel    (sel)
	);

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			new_tags[i] = (!sel.hit && sel.way == WAY_W'(i)) ? tag_s1 : tags_s1[i];
		end
	end

	assign new_row = {sel.ranks, new_tags};

	// counters
	assign hit_cnt_nx  = sat_inc(hit_cnt_q, sel.hit);
	assign miss_cnt_nx = sat_inc(miss_cnt_q, !sel.hit && action_s1 == ACT_READ);
	assign fill_cnt_nx = sat_inc(fill_cnt_q, !sel.hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			fill_cnt_q <= '0;
		end else if (s1_adv) begin
			hit_cnt_q  <= hit_cnt_nx;
			miss_cnt_q <= miss_cnt_nx;
			fill_cnt_q <= fill_cnt_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hit_s2      <= sel.hit;
			way_s2      <= sel.way;
			hit_cnt_s2  <= hit_cnt_nx;
			miss_cnt_s2 <= miss_cnt_nx;
			fill_cnt_s2 <= fill_cnt_nx;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_W'({fill_cnt_s2, miss_cnt_s2, hit_cnt_s2, way_s2, hit_s2});

	`FWLRU_ASSERT_ALWAYS(a_no_accept_clearing, clk, !(s_acc && clearing_q), "transaction accepted during clearing pass")
	`FWLRU_ASSERT(a_hit_is_read, clk, arst_n, (valid_s1 && sel.hit) |-> (action_s1 == ACT_READ), "write reported a hit")
	`FWLRU_ASSERT(a_fill_step, clk, arst_n, (s1_adv && !sel.hit && fill_cnt_q != '1) |=> (fill_cnt_q == $past(fill_cnt_q) + CNT_W'(1)), "fill count did not advance on refill")
	`FWLRU_ASSERT(a_clear_end, clk, arst_n, $fell(clearing_q) |-> ($past(clr_idx_q) == LAST_SET), "clearing pass ended early")
	`FWLRU_ASSERT(a_one_count, clk, arst_n, s1_adv |=> ((hit_cnt_q != $past(hit_cnt_q)) + (fill_cnt_q != $past(fill_cnt_q)) <= 1), "hit and fill counted together")

endmodule

// File: test/tb_four_way_lru_tag_cache.sv
// Self-checking testbench for four_way_lru_tag_cache: directed and random accesses
// over several block sizes, checked against an in-bench LRU tag predictor.
// Depends on fwlru_pkg and the four_way_lru_tag_cache RTL.
`timescale 1ns / 100ps

module tb_four_way_lru_tag_cache;
	import fwlru_pkg::*;

	localparam int SETS = NUM_SETS_DEF;
	localparam int PHASE_ITEMS = 230;
	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef struct {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] fills;
	} lookup_result_t;

	class lru_tag_scoreboard;
		logic [ADDR_W-1:0]  way_tags[SETS][WAYS];
		logic [RANKS_W-1:0] set_ranks[SETS];
		logic [OFF_W-1:0]   offset_bits;
		logic [CNT_W-1:0]   hits;
		logic [CNT_W-1:0]   misses;
		logic [CNT_W-1:0]   fills;
		lookup_result_t     predicted[$];
		int                 mismatches;

		function new();
			for (int s = 0; s < SETS; s++) begin
				set_ranks[s] = LRU_RESET;
				for (int w = 0; w < WAYS; w++)
					way_tags[s][w] = '0;
			end
			hits = '0;
			misses = '0;
			fills = '0;
			offset_bits = OFF_RESET;
			mismatches = 0;
		endfunction

		function void load_offset(logic [OFF_W-1:0] v);
			offset_bits = v;
		endfunction

		function int pending();
			return predicted.size();
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// Predict the result of one accepted access and update tags and ages.
		function void note_access(action_t act, logic [ADDR_W-1:0] addr);
			int                 shift;
			logic [ADDR_W-1:0]  blk;
			logic [ADDR_W-1:0]  tag;
			int                 set_idx;
			int                 way;
			logic               found;
			logic [RANK_W-1:0]  old_rank;
			logic [RANK_W-1:0]  k;
			logic [RANKS_W-1:0] aged;
			lookup_result_t     r;
			shift = (offset_bits < OFF_MIN) ? OFF_MIN : offset_bits;
			blk = addr >> shift;
			set_idx = blk % SETS;
			tag = blk / SETS;
			found = 1'b0;
			way = 0;
			if (act == ACT_READ) begin
				for (int w = 0; w < WAYS; w++) begin
					if (!found && way_tags[set_idx][w] == tag) begin
						found = 1'b1;
						way = w;
					end
				end
			end
			if (found) begin
				hits = bump(hits);
			end else begin
				if (act == ACT_READ)
					misses = bump(misses);
				way = 0;
				for (int w = WAYS - 1; w >= 0; w--) begin
					if (set_ranks[set_idx][RANK_W*w +: RANK_W] == RANK_OLD)
						way = w;
				end
				way_tags[set_idx][way] = tag;
				fills = bump(fills);
			end
			old_rank = set_ranks[set_idx][RANK_W*way +: RANK_W];
			aged = '0;
			for (int w = 0; w < WAYS; w++) begin
				k = set_ranks[set_idx][RANK_W*w +: RANK_W];
				if (w == way)
					k = RANK_NEW;
				else if (k > old_rank)
					k = k - 1'b1;
				aged[RANK_W*w +: RANK_W] = k;
			end
			set_ranks[set_idx] = aged;
			r.hit = found;
			r.way = way[WAY_W-1:0];
			r.hits = hits;
			r.misses = misses;
			r.fills = fills;
			predicted.push_back(r);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			lookup_result_t e;
			if (predicted.size() == 0) begin
				report($sformatf("result with no access pending, tdata=%h", data));
				return;
			end
			e = predicted.pop_front();
			if (data[0] !== e.hit || data[2:1] !== e.way || data[34:3] !== e.hits ||
			    data[66:35] !== e.misses || data[98:67] !== e.fills)
				report($sformatf({"hit %b/%b way %0d/%0d hits %0d/%0d misses %0d/%0d",
					" fills %0d/%0d (expected/actual)"},
					e.hit, data[0], e.way, data[2:1], e.hits, data[34:3],
					e.misses, data[66:35], e.fills, data[98:67]));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [OFF_W-1:0]   cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [ADDR_W-1:0]  s_axis_tdata = '0;
	logic               s_axis_tuser = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;

	lru_tag_scoreboard  sb;
	logic               sender_idle = 1'b0;
	logic               receiver_idle = 1'b0;
	int                 stall_left = 0;
	int unsigned        cycle_count = 0;

	four_way_lru_tag_cache dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL four_way_lru_tag_cache");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (stall_left == 0 && receiver_idle && $urandom_range(0, 3) == 0)
			stall_left = idle_length();
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic write_offset(input logic [OFF_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.load_offset(v);
	endtask

	task automatic send_access(input action_t act, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = (sender_idle && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= addr;
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_access(act, addr);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Accesses cluster on a few sets and a handful of tags so that sets fill,
	// hit and evict; a few go anywhere in the address space.
	task automatic run_phase(input logic [OFF_W-1:0] offset, input int count);
		int                shift;
		int                base;
		int                r;
		logic [ADDR_W-1:0] tag;
		logic [ADDR_W-1:0] set_idx;
		logic [ADDR_W-1:0] addr;
		action_t           act;
		shift = (offset < OFF_MIN) ? OFF_MIN : offset;
		base = $urandom_range(0, SETS - 4);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			act = ($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_READ;
			if (r == 0) begin
				addr = $urandom();
			end else begin
				set_idx = (r == 1) ? $urandom_range(0, SETS - 1) : base + $urandom_range(0, 3);
				tag = (r == 2) ? '1 : $urandom_range(0, 5);
				addr = (tag << (shift + 6)) | (set_idx << shift) |
					($urandom() & ((32'd1 << shift) - 1));
			end
			send_access(act, addr);
		end
	endtask

	initial begin
		logic [OFF_W-1:0] offsets[8];
		arst_n <= 1'b0;
		sb = new();
		offsets = '{3'd0, 3'd3, 3'd5, 3'd1, 3'd7, 3'd2, 3'd6, 3'd4};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_offset(OFF_RESET);

		// 128-byte blocks: set in [12:7], tag in [31:13]
		send_access(ACT_READ, 32'h0000_0000);                  // zero tag hits a cleared way
		send_access(ACT_READ, 32'hFFFF_FFFF);
		send_access(ACT_READ, 32'hFFFF_FFFF);
		send_access(ACT_WRITE, 32'h0000_0000);
		send_access(ACT_WRITE, {19'h5A5A5, 6'd5, 7'h11});      // same tag into two ways
		send_access(ACT_WRITE, {19'h5A5A5, 6'd5, 7'h22});
		send_access(ACT_READ, {19'h5A5A5, 6'd5, 7'h33});       // lowest matching way
		send_access(ACT_READ, {19'h00000, 6'd5, 7'h00});
		for (int t = 1; t <= 5; t++)
			send_access(ACT_READ, {19'(t), 6'd9, 7'(t)});
		send_access(ACT_READ, {19'd1, 6'd9, 7'd0});            // evicted by the sweep
		send_access(ACT_READ, {19'd5, 6'd9, 7'd0});
		send_access(ACT_WRITE, {19'd2, 6'd9, 7'd0});
		send_access(ACT_READ, 32'h8000_0000);
		send_access(ACT_READ, 32'h7FFF_FFFF);
		send_access(ACT_WRITE, 32'h7FFF_FFFF);
		send_access(ACT_READ, 32'h0000_007F);

		for (int p = 0; p < 8; p++) begin
			drain();
			write_offset(offsets[p]);
			sender_idle = (p % 3 != 1);
			receiver_idle = (p % 3 != 1);
			run_phase(offsets[p], PHASE_ITEMS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS four_way_lru_tag_cache");
		else
			$display("FAIL four_way_lru_tag_cache");
		$finish;
	end

endmodule
